[design/npcm_pkg.sv]
`timescale 1ns / 1ps
package npcm_pkg;

  localparam int PALETTE_SIZE = 16;
  localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_RGB    = 2'd0;
  localparam logic [1:0] MODE_LAB    = 2'd1;
  localparam logic [1:0] MODE_HYAB   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  localparam int QUO_W  = 20;
  localparam int ACC_W  = 56;
  localparam int DIST_W = 39;

  localparam logic [ACC_W-1:0] DEC_HALF = 56'd5000000000;

  // The decimal scale 1e10 is 2^10 times 5^10. The power of two is a shift;
  // the odd part is divided by a reciprocal multiply on the top 32 bits of
  // the shifted value. The recip is floor(2^54 / 5^10), so the estimate is
  // never high and at most one below the true quotient.
  localparam int          DIV_SHIFT   = 10;
  localparam int          RECIP_SHIFT = 44;
  localparam logic [23:0] DIV_ODD     = 24'd9765625;
  localparam logic [31:0] DIV_RECIP   = 32'd1844674407;

  localparam logic signed [35:0] LMS_COEF [3][3] = '{
    '{36'sd4122214708, 36'sd5363325363, 36'sd514459929},
    '{36'sd2119034982, 36'sd6806995451, 36'sd1073969566},
    '{36'sd883024619,  36'sd2817188376, 36'sd6299787005}
  };

  localparam logic signed [35:0] LAB_COEF [3][3] = '{
    '{36'sd2104542553,  36'sd7936177850,   -36'sd40720468},
    '{36'sd19779984951, -36'sd24285922050, 36'sd4505937099},
    '{36'sd259040371,   36'sd7827717662,   -36'sd8086757660}
  };

  typedef logic [2:0][17:0] lab_t;

  typedef struct packed {
    logic        is_map;
    logic        slot_ok;
    logic [3:0]  slot;
    logic [23:0] rgb;
  } npcm_item_t;

  typedef enum logic [2:0] {
    OK_IDLE,
    OK_MAC,
    OK_DIV_INIT,
    OK_DIV,
    OK_POST,
    OK_CBRT_SQ,
    OK_CBRT_CU,
    OK_DONE
  } ok_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_DIST,
    BK_SQRT,
    BK_CMP,
    BK_EMIT
  } bk_state_t;

  typedef logic [255:0][16:0] lin_tab_t;

  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = (r * r) >> 30;
    r4 = (r2 * r2) >> 30;
    return (r4 * r) >> 30;
  endfunction

  // sRGB transfer curve to linear Q0.16, evaluated at elaboration only.
  function automatic logic [16:0] lin_value(input int unsigned v);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] p;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    if (v <= 10) begin
      return 17'((64'(v) * 64'd6553600 + 64'd164730) / 64'd329460);
    end
    t  = (64'(1000 * v + 14025) << 30) / 64'd269025;
    s  = (t * t) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (pow5_q30(mid) <= s) lo = mid;
      else hi = mid - 64'd1;
    end
    p = (s * lo) >> 30;
    p = (p + 64'd8192) >> 14;
    if (p > 64'd65536) p = 64'd65536;
    return 17'(p);
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = lin_value(v);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

[design/npcm_front.sv]
`timescale 1ns / 1ps
module npcm_front import npcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [3:0]  in_entry_index,
  input  logic [23:0] in_pixel_color,
  output logic        q_push,
  output npcm_item_t  q_item,
  input  logic        q_full
);

  logic       hold_valid_r;
  logic       hold_valid_nxt;
  npcm_item_t item_r;
  npcm_item_t item_nxt;
  logic       accept;

  assign q_push   = hold_valid_r && !q_full;
  assign in_ready = !hold_valid_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_item   = item_r;

  // Tag each item so the back end only needs to look at two flags.
  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      item_nxt.is_map  = (in_kind == KIND_MAP);
      item_nxt.slot_ok = (32'(in_entry_index) < PALETTE_SIZE);
      item_nxt.slot    = in_entry_index;
      item_nxt.rgb     = in_pixel_color;
    end
  end

  always_comb begin
    if (accept) hold_valid_nxt = 1'b1;
    else if (q_push) hold_valid_nxt = 1'b0;
    else hold_valid_nxt = hold_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

[design/npcm_fifo.sv]
`timescale 1ns / 1ps
module npcm_fifo import npcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  npcm_item_t push_item,
  output logic       full,
  input  logic       pop,
  output npcm_item_t pop_item,
  output logic       valid
);

  npcm_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

[design/npcm_oklab.sv]
`timescale 1ns / 1ps
module npcm_oklab import npcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] rgb,
  output logic        done,
  output lab_t        lab
);

  ok_state_t state_r, state_nxt;

  logic                    phase_r, phase_nxt;
  logic [1:0]              row_r, row_nxt;
  logic [1:0]              col_r, col_nxt;
  logic [2:0][16:0]        lin_r, lin_nxt;
  logic [2:0][16:0]        cr_r, cr_nxt;
  lab_t                    lab_r, lab_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic                    neg_r, neg_nxt;
  logic [4:0]              step_r, step_nxt;
  logic [16:0]             root_r, root_nxt;
  logic [4:0]              bit_r, bit_nxt;
  logic [33:0]             sq_r, sq_nxt;
  logic [48:0]             tgt_r, tgt_nxt;

  logic signed [35:0]      coef;
  logic [16:0]             mac_in;
  logic signed [53:0]      prod;
  logic [ACC_W-1:0]        mag;
  logic [62:0]             est_prod;
  logic [43:0]             back_prod;
  logic [16:0]             lms_v;
  logic signed [QUO_W:0]   lab_v;
  logic [17:0]             lab_sat;
  logic [16:0]             cand;
  logic [50:0]             cube;
  logic                    le;

  assign coef   = phase_r ? LAB_COEF[row_r][col_r] : LMS_COEF[row_r][col_r];
  assign mac_in = phase_r ? cr_r[col_r] : lin_r[col_r];
  assign prod   = coef * $signed({1'b0, mac_in});
  assign mag    = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  // The shifted numerator stays below 2^42, so its top 32 bits are [41:10].
  assign est_prod  = 63'(rem_r[41:10]) * 63'(DIV_RECIP);
  assign back_prod = 44'(quo_r) * 44'(DIV_ODD);
  assign lms_v  = (quo_r > QUO_W'(65536)) ? 17'd65536 : quo_r[16:0];
  assign lab_v  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign cand   = root_r | (17'd1 << bit_r);
  assign cube   = 51'(sq_r) * 51'(cand);
  assign le     = (cube <= 51'(tgt_r));

  always_comb begin
    if (lab_v > 21'sd131071) lab_sat = 18'h1FFFF;
    else if (lab_v < -21'sd131072) lab_sat = 18'h20000;
    else lab_sat = lab_v[17:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      OK_IDLE:     if (start) state_nxt = OK_MAC;
      OK_MAC:      if (col_r == 2'd2) state_nxt = OK_DIV_INIT;
      OK_DIV_INIT: state_nxt = OK_DIV;
      OK_DIV:      if (step_r == '0) state_nxt = OK_POST;
      OK_POST: begin
        if (!phase_r) state_nxt = OK_CBRT_SQ;
        else if (row_r == 2'd2) state_nxt = OK_DONE;
        else state_nxt = OK_MAC;
      end
      OK_CBRT_SQ:  state_nxt = OK_CBRT_CU;
      OK_CBRT_CU:  state_nxt = (bit_r == '0) ? OK_MAC : OK_CBRT_SQ;
      OK_DONE:     state_nxt = OK_IDLE;
      default:     state_nxt = OK_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    lin_nxt   = lin_r;
    cr_nxt    = cr_r;
    lab_nxt   = lab_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    neg_nxt   = neg_r;
    step_nxt  = step_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    sq_nxt    = sq_r;
    tgt_nxt   = tgt_r;
    unique case (state_r)
      OK_IDLE: begin
        if (start) begin
          lin_nxt[0] = LIN_TABLE[rgb[23:16]];
          lin_nxt[1] = LIN_TABLE[rgb[15:8]];
          lin_nxt[2] = LIN_TABLE[rgb[7:0]];
          phase_nxt  = 1'b0;
          row_nxt    = 2'd0;
          col_nxt    = 2'd0;
          acc_nxt    = '0;
        end
      end
      OK_MAC: begin
        acc_nxt = acc_r + ACC_W'(prod);
        col_nxt = (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
      end
      OK_DIV_INIT: begin
        neg_nxt  = acc_r[ACC_W-1];
        rem_nxt  = (mag + DEC_HALF) >> DIV_SHIFT;
        quo_nxt  = '0;
        step_nxt = 5'd2;
      end
      OK_DIV: begin
        // Estimate, then remainder, then one correction step.
        unique case (step_r)
          5'd2: quo_nxt = QUO_W'(est_prod >> RECIP_SHIFT);
          5'd1: rem_nxt = rem_r - ACC_W'(back_prod);
          default: begin
            if (rem_r >= ACC_W'(DIV_ODD)) begin
              rem_nxt = rem_r - ACC_W'(DIV_ODD);
              quo_nxt = quo_r + 1'b1;
            end
          end
        endcase
        step_nxt = step_r - 5'd1;
      end
      OK_POST: begin
        acc_nxt = '0;
        if (!phase_r) begin
          tgt_nxt  = {lms_v, 32'd0};
          root_nxt = '0;
          bit_nxt  = 5'd16;
        end else begin
          lab_nxt[row_r] = lab_sat;
          row_nxt        = row_r + 2'd1;
        end
      end
      OK_CBRT_SQ: begin
        sq_nxt = 34'(cand) * 34'(cand);
      end
      OK_CBRT_CU: begin
        if (le) root_nxt = cand;
        if (bit_r == '0) begin
          cr_nxt[row_r] = le ? cand : root_r;
          if (row_r == 2'd2) begin
            phase_nxt = 1'b1;
            row_nxt   = 2'd0;
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
      OK_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == OK_DONE);
  assign lab  = lab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    lin_r   <= lin_nxt;
    cr_r    <= cr_nxt;
    lab_r   <= lab_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    neg_r   <= neg_nxt;
    step_r  <= step_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
    sq_r    <= sq_nxt;
    tgt_r   <= tgt_nxt;
  end

endmodule

[design/npcm_back.sv]
`timescale 1ns / 1ps
module npcm_back import npcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       q_valid,
  input  npcm_item_t q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_nearest_index
);

  bk_state_t state_r, state_nxt;

  npcm_item_t           item_r, item_nxt;
  logic [1:0]           mode_r;
  logic [PAL_IDX_W-1:0] j_r, j_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [37:0]          sum_r, sum_nxt;
  logic [17:0]          dl_r, dl_nxt;
  logic [18:0]          root_r, root_nxt;
  logic [4:0]           bit_r, bit_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic [DIST_W-1:0]    best_r, best_nxt;
  logic [PAL_IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [3:0]           out_idx_r, out_idx_nxt;
  logic [23:0]          pal_rgb_r [PALETTE_SIZE];
  lab_t                 pal_lab_r [PALETTE_SIZE];

  logic                 ok_start;
  logic                 ok_done;
  lab_t                 ok_lab;
  logic                 hyab;
  logic                 pal_we;
  logic [7:0]           pix_byte;
  logic [7:0]           pal_byte;
  logic [7:0]           byte_mag;
  logic signed [18:0]   lab_diff;
  logic [17:0]          lab_mag;
  logic [17:0]          mag;
  logic [35:0]          sq;
  logic [18:0]          scand;
  logic                 sq_le;
  logic                 take;
  logic                 emit_ok;

  npcm_oklab u_oklab (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ok_start),
    .rgb   (q_item.rgb),
    .done  (ok_done),
    .lab   (ok_lab)
  );

  assign hyab    = (mode_r != MODE_RGB) && (mode_r != MODE_LAB);
  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    unique case (k_r)
      2'd0:    begin pix_byte = item_r.rgb[23:16]; pal_byte = pal_rgb_r[j_r][23:16]; end
      2'd1:    begin pix_byte = item_r.rgb[15:8];  pal_byte = pal_rgb_r[j_r][15:8];  end
      default: begin pix_byte = item_r.rgb[7:0];   pal_byte = pal_rgb_r[j_r][7:0];   end
    endcase
  end

  assign byte_mag = (pix_byte >= pal_byte) ? pix_byte - pal_byte : pal_byte - pix_byte;
  assign lab_diff = $signed({ok_lab[k_r][17], ok_lab[k_r]})
                  - $signed({pal_lab_r[j_r][k_r][17], pal_lab_r[j_r][k_r]});
  assign lab_mag  = lab_diff[18] ? 18'(-lab_diff) : lab_diff[17:0];
  assign mag      = (mode_r == MODE_RGB) ? {10'd0, byte_mag} : lab_mag;
  assign sq       = 36'(mag) * 36'(mag);
  assign scand    = root_r | (19'd1 << bit_r);
  assign sq_le    = (38'(scand) * 38'(scand)) <= sum_r;
  assign take     = (j_r == '0) || (dist_r < best_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_CONV;
      BK_CONV: if (ok_done) state_nxt = item_r.is_map ? BK_DIST : BK_IDLE;
      BK_DIST: begin
        if (k_r == 2'd2) state_nxt = hyab ? BK_SQRT : BK_CMP;
      end
      BK_SQRT: if (bit_r == '0) state_nxt = BK_CMP;
      BK_CMP:  state_nxt = (j_r == PAL_IDX_W'(PALETTE_SIZE - 1)) ? BK_EMIT : BK_DIST;
      BK_EMIT: if (emit_ok) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    ok_start     = 1'b0;
    pal_we       = 1'b0;
    item_nxt     = item_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    sum_nxt      = sum_r;
    dl_nxt       = dl_r;
    root_nxt     = root_r;
    bit_nxt      = bit_r;
    dist_nxt     = dist_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    out_idx_nxt  = out_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          ok_start = 1'b1;
          item_nxt = q_item;
        end
      end
      BK_CONV: begin
        if (ok_done) begin
          pal_we  = !item_r.is_map && item_r.slot_ok;
          j_nxt   = '0;
          k_nxt   = 2'd0;
          sum_nxt = '0;
        end
      end
      BK_DIST: begin
        if (hyab && (k_r == 2'd0)) dl_nxt = mag;
        else sum_nxt = sum_r + 38'(sq);
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          root_nxt = '0;
          bit_nxt  = 5'd18;
          dist_nxt = DIST_W'(sum_r + 38'(sq));
        end
      end
      BK_SQRT: begin
        if (sq_le) root_nxt = scand;
        bit_nxt = bit_r - 5'd1;
        if (bit_r == '0) begin
          dist_nxt = DIST_W'(dl_r) + DIST_W'(sq_le ? scand : root_r);
        end
      end
      BK_CMP: begin
        if (take) begin
          best_nxt     = dist_r;
          best_idx_nxt = j_r;
        end
        j_nxt   = j_r + 1'b1;
        k_nxt   = 2'd0;
        sum_nxt = '0;
      end
      BK_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 4'(best_idx_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      mode_r      <= MODE_HYAB;
      out_valid_r <= 1'b0;
      for (int e = 0; e < PALETTE_SIZE; e++) begin
        pal_rgb_r[e] <= '0;
        pal_lab_r[e] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      if (pal_we) begin
        pal_rgb_r[PAL_IDX_W'(item_r.slot)] <= item_r.rgb;
        pal_lab_r[PAL_IDX_W'(item_r.slot)] <= ok_lab;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    sum_r      <= sum_nxt;
    dl_r       <= dl_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    dist_r     <= dist_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    ok_done |-> state_r == BK_CONV)
    else $error("color conversion finished outside the conversion phase");

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BK_IDLE && q_valid)
    else $error("queue popped while busy or empty");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == BK_EMIT)
    else $error("result raised without finishing a palette search");

endmodule

[design/nearest_palette_color_mapper_top.sv]
`timescale 1ns / 1ps
// Nearest palette color mapper. Each input transfer is either a palette load
// (in_kind 0), which stores in_pixel_color and its OkLab value in slot
// in_entry_index and produces no result, or a pixel (in_kind 1), which
// produces one output transfer carrying the index of the closest of the 16
// palette entries, the lowest index winning ties. After reset the palette is
// all black and metric_mode is HyAB. cfg_wdata selects the metric when
// cfg_we is high: 0 squared sRGB, 1 squared OkLab, 2 or 3 HyAB; write it only
// while no item is in flight. A front stage registers and tags the input and
// feeds a two-entry queue, so the input side keeps taking transfers while the
// back end works and while a result waits in the output register, until the
// queue and the front register are full. The back end handles one item at a
// time. The sRGB to OkLab conversion is a sequencer with one multiplier
// shared by both matrix products, a reciprocal multiply with one correction
// step for the decimal rounding and a bit-per-step cube root; the conversion
// is the whole cost of a load. A pixel then scans the palette one entry at a
// time, and HyAB mode adds a bit-serial square root for each entry.
module nearest_palette_color_mapper_top import npcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [3:0]  in_entry_index,
  input  logic [23:0] in_pixel_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_nearest_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  // Queue between the tagging front stage and the search engine.
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  npcm_item_t q_in_item;
  npcm_item_t q_out_item;

  npcm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_pixel_color (in_pixel_color),
    .q_push         (q_push),
    .q_item         (q_in_item),
    .q_full         (q_full)
  );

  npcm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .valid     (q_valid)
  );

  // The back end owns the metric register, the palette and the output register.
  npcm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .q_valid           (q_valid),
    .q_item            (q_out_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_nearest_index (out_nearest_index)
  );

endmodule

[tb/npcm_checker.sv]
`timescale 1ns / 1ps
module npcm_checker import npcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_kind,
  input  logic [3:0]  in_entry_index,
  input  logic [23:0] in_pixel_color,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_nearest_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  output int          mismatches,
  output int          pending,
  output int          pixels_seen,
  output int          loads_seen
);

  localparam longint DSCALE = 64'sd10000000000;
  localparam longint DHALF  = 64'sd5000000000;
  localparam longint LMS_M [3][3] = '{
    '{64'sd4122214708, 64'sd5363325363, 64'sd514459929},
    '{64'sd2119034982, 64'sd6806995451, 64'sd1073969566},
    '{64'sd883024619, 64'sd2817188376, 64'sd6299787005}};
  localparam longint LAB_M [3][3] = '{
    '{64'sd2104542553, 64'sd7936177850, -64'sd40720468},
    '{64'sd19779984951, -64'sd24285922050, 64'sd4505937099},
    '{64'sd259040371, 64'sd7827717662, -64'sd8086757660}};

  typedef logic signed [17:0] lab_vec_t [3];

  logic [1:0]  metric;
  logic [23:0] pal_rgb [16];
  lab_vec_t    pal_lab [16];
  logic [3:0]  nearest_q [$];

  function automatic logic [63:0] fifth_power(logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = (r * r) >> 30;
    r4 = (r2 * r2) >> 30;
    return (r4 * r) >> 30;
  endfunction

  // Gamma expansion of one 8-bit channel to Q0.16.
  function automatic longint gamma_expand(logic [7:0] v);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    if (v <= 8'd10) return (64'(v) * 6553600 + 164730) / 329460;
    t  = (64'(1000 * int'(v) + 14025) << 30) / 64'd269025;
    s  = (t * t) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (fifth_power(mid) <= s) lo = mid;
      else hi = mid - 1;
    end
    p = (((s * lo) >> 30) + 8192) >> 14;
    if (p > 65536) p = 65536;
    return longint'(p);
  endfunction

  function automatic longint cube_root(longint x);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    target = 64'(x) << 32;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid * mid <= target) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  function automatic longint round_decimal(longint n);
    if (n >= 0) return (n + DHALF) / DSCALE;
    return -((-n + DHALF) / DSCALE);
  endfunction

  function automatic void pixel_to_lab(logic [23:0] rgb, output lab_vec_t lab);
    longint lin [3];
    longint cr [3];
    longint acc;
    longint v;
    lin[0] = gamma_expand(rgb[23:16]);
    lin[1] = gamma_expand(rgb[15:8]);
    lin[2] = gamma_expand(rgb[7:0]);
    for (int i = 0; i < 3; i++) begin
      acc = LMS_M[i][0] * lin[0] + LMS_M[i][1] * lin[1] + LMS_M[i][2] * lin[2];
      v = round_decimal(acc);
      if (v > 65536) v = 65536;
      if (v < 0) v = 0;
      cr[i] = cube_root(v);
    end
    for (int i = 0; i < 3; i++) begin
      acc = LAB_M[i][0] * cr[0] + LAB_M[i][1] * cr[1] + LAB_M[i][2] * cr[2];
      v = round_decimal(acc);
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      lab[i] = 18'(v);
    end
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] sq_gap(longint x, longint y);
    longint d;
    d = x - y;
    if (d < 0) d = -d;
    return 64'(d) * 64'(d);
  endfunction

  function automatic logic [63:0] color_distance(logic [23:0] rgb, lab_vec_t lab, int j);
    logic [23:0] q;
    longint dl;
    q = pal_rgb[j];
    if (metric == MODE_RGB)
      return sq_gap(rgb[23:16], q[23:16]) + sq_gap(rgb[15:8], q[15:8])
           + sq_gap(rgb[7:0], q[7:0]);
    if (metric == MODE_LAB)
      return sq_gap(lab[0], pal_lab[j][0]) + sq_gap(lab[1], pal_lab[j][1])
           + sq_gap(lab[2], pal_lab[j][2]);
    // HyAB, also for the unused code 3.
    dl = longint'(lab[0]) - longint'(pal_lab[j][0]);
    if (dl < 0) dl = -dl;
    return 64'(dl) + int_sqrt(sq_gap(lab[1], pal_lab[j][1]) + sq_gap(lab[2], pal_lab[j][2]));
  endfunction

  function automatic logic [3:0] nearest_entry(logic [23:0] rgb, lab_vec_t lab);
    logic [63:0] best_d;
    logic [63:0] d;
    logic [3:0]  best;
    best = 0;
    best_d = color_distance(rgb, lab, 0);
    for (int j = 1; j < 16; j++) begin
      d = color_distance(rgb, lab, j);
      if (d < best_d) begin
        best_d = d;
        best = 4'(j);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    lab_vec_t   lab;
    logic [3:0] want;
    if (!rst_n) begin
      metric <= MODE_HYAB;
      for (int j = 0; j < 16; j++) begin
        pal_rgb[j] = '0;
        pal_lab[j] = '{default: '0};
      end
      nearest_q.delete();
      mismatches <= 0;
      pixels_seen <= 0;
      loads_seen <= 0;
    end else begin
      if (cfg_we) metric <= cfg_wdata;
      if (in_valid && in_ready) begin
        pixel_to_lab(in_pixel_color, lab);
        if (in_kind == KIND_LOAD) begin
          pal_rgb[in_entry_index] = in_pixel_color;
          pal_lab[in_entry_index] = lab;
          loads_seen <= loads_seen + 1;
        end else begin
          nearest_q.push_back(nearest_entry(in_pixel_color, lab));
          pixels_seen <= pixels_seen + 1;
        end
      end
      if (out_valid && out_ready) begin
        if (nearest_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result, nearest_index=%0d", $realtime,
                     out_nearest_index);
          mismatches <= mismatches + 1;
        end else begin
          want = nearest_q.pop_front();
          if (want !== out_nearest_index) begin
            if (mismatches < 10)
              $display("%0t: nearest_index expected %0d, got %0d", $realtime, want,
                       out_nearest_index);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= nearest_q.size();
  end

endmodule

[tb/nearest_palette_color_mapper_top_tb.sv]
`timescale 1ns / 1ps
module nearest_palette_color_mapper_top_tb;
  import npcm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [3:0]  in_entry_index;
  logic [23:0] in_pixel_color;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_nearest_index;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  int          mismatches;
  int          pending;
  int          pixels_seen;
  int          loads_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycles = 0;

  nearest_palette_color_mapper_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_entry_index(in_entry_index), .in_pixel_color(in_pixel_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_nearest_index(out_nearest_index),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // The checker watches every transfer, predicts the nearest entry and
  // reports how many results disagreed.
  npcm_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_entry_index(in_entry_index), .in_pixel_color(in_pixel_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_nearest_index(out_nearest_index),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending),
    .pixels_seen(pixels_seen), .loads_seen(loads_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random with the current idle percentage.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Even in HyAB mode with heavy output stalls, a few thousand items stay well
  // below this limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd8000000) begin
      $display("nearest_palette_color_mapper_top verification failed");
      $finish;
    end
  end

  // One input transfer. A random gap may come first; the valid is raised in
  // the same step as the previous acceptance when there is no gap, so the
  // signal only ever gets one assignment per step.
  task automatic push_item(logic kind, logic [3:0] slot, logic [23:0] color);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= slot;
    in_pixel_color <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending, wait for every expected result, then give the back end
  // time to finish any trailing palette loads, which produce no result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_metric(logic [1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Channels lean toward the dark linear segment boundary and the extremes.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(9, 12));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_color();
    if ($urandom_range(3) == 0) return 24'($urandom);
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  initial begin
    logic [1:0] modes [4];
    int         idle_s [3];
    int         idle_r [3];
    modes  = '{MODE_RGB, MODE_LAB, MODE_HYAB, MODE_UNUSED};
    idle_s = '{31, 49, 0};
    idle_r = '{49, 31, 0};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_LOAD;
    in_entry_index = '0;
    in_pixel_color = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = MODE_HYAB;
    send_idle_pct  = idle_s[0];
    recv_idle_pct  = idle_r[0];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting in the reset metric (HyAB) on an all-black
    // palette, so the first pixel must map to entry zero.
    push_item(KIND_MAP, 4'd0, 24'hFFFFFF);
    push_item(KIND_LOAD, 4'd15, 24'hFFFFFF);
    push_item(KIND_LOAD, 4'd1, 24'hFF0000);
    push_item(KIND_LOAD, 4'd2, 24'h00FF00);
    push_item(KIND_LOAD, 4'd3, 24'h0000FF);
    push_item(KIND_LOAD, 4'd4, 24'h0A0A0A);
    push_item(KIND_LOAD, 4'd5, 24'h0B0B0B);
    // Duplicate entries: the lower index must win the tie.
    push_item(KIND_LOAD, 4'd6, 24'h808080);
    push_item(KIND_LOAD, 4'd7, 24'h808080);
    push_item(KIND_MAP, 4'd0, 24'h808080);
    push_item(KIND_MAP, 4'd9, 24'hFFFFFF);
    push_item(KIND_MAP, 4'd0, 24'h000000);
    push_item(KIND_MAP, 4'd0, 24'h0B0B0A);
    push_item(KIND_MAP, 4'd0, 24'hF01008);
    set_metric(MODE_RGB);
    push_item(KIND_MAP, 4'd0, 24'h0A0A0A);
    push_item(KIND_MAP, 4'd0, 24'h10F010);
    set_metric(MODE_LAB);
    push_item(KIND_MAP, 4'd0, 24'h0808F8);
    push_item(KIND_MAP, 4'd0, 24'h7F7F81);
    // The unused metric code must behave as HyAB.
    set_metric(MODE_UNUSED);
    push_item(KIND_MAP, 4'd0, 24'h555555);
    push_item(KIND_MAP, 4'd0, 24'hFFFF00);

    // Random part: each idle pattern runs through every metric code. About
    // a quarter of the transfers reload palette slots.
    for (int p = 0; p < 3; p++) begin
      for (int m = 0; m < 4; m++) begin
        set_metric(modes[m]);
        send_idle_pct = idle_s[p];
        recv_idle_pct = idle_r[p];
        for (int k = 0; k < 160; k++) begin
          if ($urandom_range(3) == 0)
            push_item(KIND_LOAD, 4'($urandom_range(15)), pick_color());
          else
            push_item(KIND_MAP, 4'($urandom_range(15)), pick_color());
        end
      end
    end

    drain();
    $display("Covered %0d pixel mappings and %0d palette loads", pixels_seen, loads_seen);
    $display("over all four metric codes and three handshake idle patterns.");
    if (mismatches == 0) begin
      $display("nearest_palette_color_mapper_top verification clean");
    end else begin
      $display("nearest_palette_color_mapper_top verification failed");
    end
    $finish;
  end

endmodule
